// ===== rtl/core/atcf_pkg.sv =====
`default_nettype none

package atcf_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;
    localparam int SAMPLE_W   = 16;
    localparam int OUT_W      = 16;
    localparam int ONE_G_W    = 15;
    localparam int PCT_W      = 7;
    localparam int ALPHA_W    = 17;
    localparam int DEV_W      = 17;
    localparam int LIM_W      = 17;
    localparam int LIM2_W     = 34;
    localparam int PCTG_W     = 22;
    localparam int RND_SHIFT  = 16;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;
    localparam logic [ALPHA_W-1:0] ALPHA_RST = 17'd6554;
    localparam logic [ONE_G_W-1:0] ONE_G_RST = 15'd16384;
    localparam logic [PCT_W-1:0]   PCT_RST   = 7'd10;
    localparam logic [PCT_W-1:0]   PCT_DIV   = 7'd100;
    localparam logic [RND_SHIFT-1:0] RND_HALF = 16'h8000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_REF_X,
        CFG_REF_Y,
        CFG_REF_Z,
        CFG_REF_VALID,
        CFG_ONE_G,
        CFG_PERCENT,
        CFG_ALPHA
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_IDLE,
        S_GLSQ,
        S_GLRT,
        S_LIMM,
        S_LIMD,
        S_LIMLO,
        S_LIMHI,
        S_MAG,
        S_CHK,
        S_DOT,
        S_SRT,
        S_DEN,
        S_QDIV,
        S_FILT,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        OP_MUL,
        OP_DIV,
        OP_SQRT
    } t_arith_op;

    typedef struct packed {
        logic      start;
        t_arith_op op;
    } t_arith_req;

    function automatic int max3(input int a, input int b, input int c);
        int m;
        m = (a > b) ? a : b;
        return (m > c) ? m : c;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/atcf_arith.sv =====
`default_nettype none

module atcf_arith #(
    parameter int SW = 16,
    parameter int MW = 17,
    parameter int NW = 47,
    parameter int DW = 33
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  atcf_pkg::t_arith_req     i_req,
    input  logic [MW-1:0]            i_a,
    input  logic [MW-1:0]            i_b,
    input  logic [NW-1:0]            i_num,
    input  logic [DW-1:0]            i_den,
    input  logic [2*SW-1:0]          i_rad,
    output logic                     o_done,
    output logic [2*MW-1:0]          o_prod,
    output logic [NW-1:0]            o_quot,
    output logic [SW-1:0]            o_root
);
    import atcf_pkg::*;

    localparam int PW = 2 * MW;
    localparam int CW = $clog2(max3(NW, MW, SW) + 1);

    logic            r_busy;
    logic            r_done;
    logic [CW-1:0]   r_cnt;
    t_arith_op       r_op;
    logic [MW-1:0]   r_ma;
    logic [PW-1:0]   r_mb;
    logic [PW-1:0]   r_acc;
    logic [NW-1:0]   r_dq;
    logic [DW-1:0]   r_rem;
    logic [DW-1:0]   r_dd;
    logic [2*SW-1:0] r_rad;
    logic [SW+1:0]   r_srem;
    logic [SW-1:0]   r_root;

    logic [CW-1:0]   w_count;
    logic [DW:0]     w_rsh;
    logic [DW:0]     w_rsub;
    logic            w_rge;
    logic [SW+3:0]   w_ssh;
    logic [SW+3:0]   w_trial;
    logic [SW+3:0]   w_ssub;
    logic            w_sge;

    always_comb begin
        unique case (i_req.op)
            OP_MUL:  w_count = CW'(MW);
            OP_DIV:  w_count = CW'(NW);
            OP_SQRT: w_count = CW'(SW);
            default: w_count = CW'(MW);
        endcase
    end

    assign w_rsh   = {r_rem, r_dq[NW-1]};
    assign w_rge   = (w_rsh >= {1'b0, r_dd});
    assign w_rsub  = w_rsh - {1'b0, r_dd};
    assign w_ssh   = {r_srem, r_rad[2*SW-1 -: 2]};
    assign w_trial = (SW+4)'({r_root, 2'b01});
    assign w_sge   = (w_ssh >= w_trial);
    assign w_ssub  = w_ssh - w_trial;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= w_count;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_op   <= i_req.op;
            r_ma   <= i_a;
            r_mb   <= PW'(i_b);
            r_acc  <= '0;
            r_dq   <= i_num;
            r_rem  <= '0;
            r_dd   <= i_den;
            r_rad  <= i_rad;
            r_srem <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            case (r_op)
                OP_MUL: begin
                    if (r_ma[0]) begin
                        r_acc <= r_acc + r_mb;
                    end
                    r_ma <= r_ma >> 1;
                    r_mb <= r_mb << 1;
                end
                OP_DIV: begin
                    r_rem <= w_rge ? w_rsub[DW-1:0] : w_rsh[DW-1:0];
                    r_dq  <= {r_dq[NW-2:0], w_rge};
                end
                OP_SQRT: begin
                    r_srem <= w_sge ? w_ssub[SW+1:0] : w_ssh[SW+1:0];
                    r_root <= {r_root[SW-2:0], w_sge};
                    r_rad  <= r_rad << 2;
                end
                default: begin
                    r_ma <= r_ma;
                end
            endcase
        end
    end

    assign o_done = r_done;
    assign o_prod = r_acc;
    assign o_quot = r_dq;
    assign o_root = r_root;

    a_no_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.start |-> !r_busy) else $error("start while busy");
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> !r_busy) else $error("done while busy");
    a_busy_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_cnt != '0)) else $error("busy with empty count");

endmodule

`default_nettype wire

// ===== rtl/core/accel_tilt_cosine_filter.sv =====
// A passing item is worked through in steps by one shared bit-serial multiply/divide/sqrt unit:
// sample magnitude squares, limit check, dot product, sqrt, denominator, quotient, filter update.
// A reference write makes the next processed item recompute the reference length; a limit write
// makes it recompute the squared limits. Throughput: one item at a time, accepted only in idle;
// a zero divisor skips the divide, skipped items stay in idle. A stalled result holds the block.
// Reset: synchronous active low; filter state returns to 1.0, config registers to their defaults.
`default_nettype none

module accel_tilt_cosine_filter #(
    parameter int SAMPLE_BITS      = 16,
    parameter int COSINE_FRAC_BITS = 14
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_valid,
    output logic                                   o_ready,
    input  logic signed [atcf_pkg::SAMPLE_W-1:0]   i_accel_x,
    input  logic signed [atcf_pkg::SAMPLE_W-1:0]   i_accel_y,
    input  logic signed [atcf_pkg::SAMPLE_W-1:0]   i_accel_z,
    input  logic                                   i_last_in_batch,
    output logic                                   o_valid,
    input  logic                                   i_ready,
    output logic signed [atcf_pkg::OUT_W-1:0]      o_tilt_cosine,
    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [atcf_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [atcf_pkg::CFG_DATA_W-1:0]        i_cfg_data
);
    import atcf_pkg::*;

    localparam int S     = SAMPLE_BITS;
    localparam int F     = COSINE_FRAC_BITS;
    localparam int MW    = max3(ALPHA_W, F + 2, S);
    localparam int PW    = 2 * MW;
    localparam int NW    = 2 * S + F + 1;
    localparam int DW    = 2 * S + 1;
    localparam int YW    = F + 2;
    localparam int MSQ_W = 2 * S;
    localparam int CMPW  = max3(MSQ_W, LIM2_W, 1);
    localparam logic signed [YW-1:0] ONE_Y = {2'b01, {F{1'b0}}};

    function automatic logic [S-1:0] mag_s(input logic [S-1:0] v);
        return v[S-1] ? (~v + 1'b1) : v;
    endfunction

    // configuration
    logic [S-1:0]         r_ref_x, r_ref_y, r_ref_z;
    logic                 r_ref_valid;
    logic [ONE_G_W-1:0]   r_one_g;
    logic [PCT_W-1:0]     r_pct;
    logic [ALPHA_W-1:0]   r_alpha;

    t_state               r_state, n_state;
    logic                 r_issued, n_issued;
    logic [1:0]           r_k, n_k;
    logic [MSQ_W-1:0]     r_acc, n_acc;
    logic signed [MSQ_W:0] r_dot, n_dot;
    logic [S-1:0]         r_glen, n_glen;
    logic [S-1:0]         r_sm, n_sm;
    logic [MSQ_W-1:0]     r_den, n_den;
    logic [DEV_W-1:0]     r_dev, n_dev;
    logic [LIM2_W-1:0]    r_lo2, n_lo2;
    logic [LIM2_W-1:0]    r_hi2, n_hi2;
    logic signed [YW-1:0] r_x, n_x;
    logic signed [YW-1:0] r_y, n_y;
    logic                 r_failed, n_failed;
    logic                 r_gstale, n_gstale;
    logic                 r_lstale, n_lstale;
    logic                 r_last, n_last;
    logic [S-1:0]         r_sx, n_sx, r_sy, n_sy, r_sz, n_sz;
    logic                 r_out_valid, n_out_valid;
    logic signed [OUT_W-1:0] r_out, n_out;

    t_arith_req           w_req;
    logic [MW-1:0]        w_a, w_b;
    logic [NW-1:0]        w_num;
    logic [DW-1:0]        w_dden;
    logic [MSQ_W-1:0]     w_rad;
    logic                 w_done;
    logic [PW-1:0]        w_prod;
    logic [NW-1:0]        w_quot;
    logic [S-1:0]         w_root;

    logic [S-1:0]         w_ref_k, w_smp_k;
    logic [ONE_G_W-1:0]   w_lower;
    logic [LIM_W-1:0]     w_upper;
    logic [MSQ_W-1:0]     w_dot_mag;
    logic signed [YW-1:0] w_qc;
    logic signed [YW-1:0] w_xq;
    logic signed [YW:0]   w_diff;
    logic [YW-1:0]        w_diff_mag;
    logic [ALPHA_W-1:0]   w_alpha_c;
    logic [PW-1:0]        w_rnd;
    logic signed [YW:0]   w_step;
    logic signed [YW:0]   w_ynew;
    logic                 w_fail;
    logic                 w_dot_neg;

    always_comb begin
        case (r_k)
            2'd0:    begin w_ref_k = r_ref_x; w_smp_k = r_sx; end
            2'd1:    begin w_ref_k = r_ref_y; w_smp_k = r_sy; end
            default: begin w_ref_k = r_ref_z; w_smp_k = r_sz; end
        endcase
    end

    assign w_lower    = (r_dev > DEV_W'(r_one_g)) ? '0 : (r_one_g - r_dev[ONE_G_W-1:0]);
    assign w_upper    = LIM_W'(r_one_g) + LIM_W'(r_dev);
    assign w_dot_mag  = r_dot[MSQ_W] ? MSQ_W'(-r_dot) : r_dot[MSQ_W-1:0];
    assign w_qc       = (w_quot > NW'(ONE_Y)) ? ONE_Y : $signed(w_quot[YW-1:0]);
    assign w_xq       = r_dot[MSQ_W] ? -w_qc : w_qc;
    assign w_diff     = (YW+1)'(r_x) - (YW+1)'(r_y);
    assign w_diff_mag = w_diff[YW] ? YW'(-w_diff) : w_diff[YW-1:0];
    assign w_alpha_c  = (r_alpha > ALPHA_ONE) ? ALPHA_ONE : r_alpha;
    assign w_rnd      = (w_prod + PW'(RND_HALF)) >> RND_SHIFT;
    assign w_step     = $signed({1'b0, w_rnd[YW-1:0]});
    assign w_ynew     = w_diff[YW] ? ((YW+1)'(r_y) - w_step) : ((YW+1)'(r_y) + w_step);
    assign w_fail     = (CMPW'(r_acc) < CMPW'(r_lo2)) || (CMPW'(r_acc) > CMPW'(r_hi2));
    assign w_dot_neg  = w_ref_k[S-1] ^ w_smp_k[S-1];

    // operand selection for the serial unit
    always_comb begin
        w_req.start = 1'b0;
        w_req.op    = OP_MUL;
        w_a         = '0;
        w_b         = '0;
        w_num       = '0;
        w_dden      = '0;
        w_rad       = r_acc;
        unique case (r_state)
            S_GLSQ: begin
                w_a = MW'(mag_s(w_ref_k));
                w_b = MW'(mag_s(w_ref_k));
            end
            S_GLRT, S_SRT: w_req.op = OP_SQRT;
            S_LIMM: begin
                w_a = MW'(r_pct);
                w_b = MW'(r_one_g);
            end
            S_LIMD: begin
                w_req.op = OP_DIV;
                w_num    = NW'(w_prod[PCTG_W-1:0]);
                w_dden   = DW'(PCT_DIV);
            end
            S_LIMLO: begin
                w_a = MW'(w_lower);
                w_b = MW'(w_lower);
            end
            S_LIMHI: begin
                w_a = MW'(w_upper);
                w_b = MW'(w_upper);
            end
            S_MAG: begin
                w_a = MW'(mag_s(w_smp_k));
                w_b = MW'(mag_s(w_smp_k));
            end
            S_DOT: begin
                w_a = MW'(mag_s(w_ref_k));
                w_b = MW'(mag_s(w_smp_k));
            end
            S_DEN: begin
                w_a = MW'(r_glen);
                w_b = MW'(r_sm);
            end
            S_QDIV: begin
                w_req.op = OP_DIV;
                w_num    = NW'({w_dot_mag, {(F+1){1'b0}}}) + NW'(r_den);
                w_dden   = {r_den, 1'b0};
            end
            S_FILT: begin
                w_a = MW'(w_alpha_c);
                w_b = MW'(w_diff_mag);
            end
            default: w_req.op = OP_MUL;
        endcase
        if (r_state != S_IDLE && r_state != S_CHK && r_state != S_OUT && !r_issued) begin
            w_req.start = 1'b1;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_issued    = r_issued;
        n_k         = r_k;
        n_acc       = r_acc;
        n_dot       = r_dot;
        n_glen      = r_glen;
        n_sm        = r_sm;
        n_den       = r_den;
        n_dev       = r_dev;
        n_lo2       = r_lo2;
        n_hi2       = r_hi2;
        n_x         = r_x;
        n_y         = r_y;
        n_failed    = r_failed;
        n_gstale    = r_gstale;
        n_lstale    = r_lstale;
        n_last      = r_last;
        n_sx        = r_sx;
        n_sy        = r_sy;
        n_sz        = r_sz;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        if (w_req.start) begin
            n_issued = 1'b1;
        end
        if (w_done) begin
            n_issued = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_sx   = i_accel_x[S-1:0];
                    n_sy   = i_accel_y[S-1:0];
                    n_sz   = i_accel_z[S-1:0];
                    n_last = i_last_in_batch;
                    if (!r_ref_valid || r_failed) begin
                        if (i_last_in_batch) begin
                            n_failed = 1'b0;
                        end
                    end else begin
                        n_acc   = '0;
                        n_k     = '0;
                        n_state = r_gstale ? S_GLSQ : (r_lstale ? S_LIMM : S_MAG);
                    end
                end
            end
            S_GLSQ: begin
                if (w_done) begin
                    n_acc = r_acc + w_prod[MSQ_W-1:0];
                    if (r_k == 2'd2) begin
                        n_k     = '0;
                        n_state = S_GLRT;
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            S_GLRT: begin
                if (w_done) begin
                    n_glen   = w_root;
                    n_gstale = 1'b0;
                    n_acc    = '0;
                    n_state  = r_lstale ? S_LIMM : S_MAG;
                end
            end
            S_LIMM: begin
                if (w_done) begin
                    n_state = S_LIMD;
                end
            end
            S_LIMD: begin
                if (w_done) begin
                    n_dev   = w_quot[DEV_W-1:0];
                    n_state = S_LIMLO;
                end
            end
            S_LIMLO: begin
                if (w_done) begin
                    n_lo2   = w_prod[LIM2_W-1:0];
                    n_state = S_LIMHI;
                end
            end
            S_LIMHI: begin
                if (w_done) begin
                    n_hi2    = w_prod[LIM2_W-1:0];
                    n_lstale = 1'b0;
                    n_acc    = '0;
                    n_k      = '0;
                    n_state  = S_MAG;
                end
            end
            S_MAG: begin
                if (w_done) begin
                    n_acc = r_acc + w_prod[MSQ_W-1:0];
                    if (r_k == 2'd2) begin
                        n_k     = '0;
                        n_state = S_CHK;
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            S_CHK: begin
                if (w_fail) begin
                    n_failed = !r_last;
                    n_state  = S_IDLE;
                end else begin
                    n_dot   = '0;
                    n_k     = '0;
                    n_state = S_DOT;
                end
            end
            S_DOT: begin
                if (w_done) begin
                    if (w_dot_neg) begin
                        n_dot = r_dot - $signed({1'b0, w_prod[MSQ_W-1:0]});
                    end else begin
                        n_dot = r_dot + $signed({1'b0, w_prod[MSQ_W-1:0]});
                    end
                    if (r_k == 2'd2) begin
                        n_k     = '0;
                        n_state = S_SRT;
                    end else begin
                        n_k = r_k + 1'b1;
                    end
                end
            end
            S_SRT: begin
                if (w_done) begin
                    n_sm    = w_root;
                    n_state = S_DEN;
                end
            end
            S_DEN: begin
                if (w_done) begin
                    n_den = w_prod[MSQ_W-1:0];
                    if (w_prod[MSQ_W-1:0] == '0) begin
                        n_x     = '0;
                        n_state = S_FILT;
                    end else begin
                        n_state = S_QDIV;
                    end
                end
            end
            S_QDIV: begin
                if (w_done) begin
                    n_x     = w_xq;
                    n_state = S_FILT;
                end
            end
            S_FILT: begin
                if (w_done) begin
                    n_y = w_ynew[YW-1:0];
                    if (r_last) begin
                        n_failed = 1'b0;
                        n_state  = S_OUT;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_OUT: begin
                if (!r_out_valid || i_ready) begin
                    n_out_valid = 1'b1;
                    n_out       = OUT_W'(r_y);
                    n_state     = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_REF_X, CFG_REF_Y, CFG_REF_Z: n_gstale = 1'b1;
                CFG_ONE_G, CFG_PERCENT:          n_lstale = 1'b1;
                default:                         n_lstale = n_lstale;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ref_x     <= '0;
            r_ref_y     <= '0;
            r_ref_z     <= '0;
            r_ref_valid <= 1'b0;
            r_one_g     <= ONE_G_RST;
            r_pct       <= PCT_RST;
            r_alpha     <= ALPHA_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_REF_X:     r_ref_x     <= i_cfg_data[S-1:0];
                CFG_REF_Y:     r_ref_y     <= i_cfg_data[S-1:0];
                CFG_REF_Z:     r_ref_z     <= i_cfg_data[S-1:0];
                CFG_REF_VALID: r_ref_valid <= i_cfg_data[0];
                CFG_ONE_G:     r_one_g     <= i_cfg_data[ONE_G_W-1:0];
                CFG_PERCENT:   r_pct       <= i_cfg_data[PCT_W-1:0];
                CFG_ALPHA:     r_alpha     <= i_cfg_data[ALPHA_W-1:0];
                default:       r_ref_valid <= r_ref_valid;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_issued    <= 1'b0;
            r_k         <= '0;
            r_failed    <= 1'b0;
            r_gstale    <= 1'b0;
            r_lstale    <= 1'b1;
            r_glen      <= '0;
            r_y         <= ONE_Y;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_issued    <= n_issued;
            r_k         <= n_k;
            r_failed    <= n_failed;
            r_gstale    <= n_gstale;
            r_lstale    <= n_lstale;
            r_glen      <= n_glen;
            r_y         <= n_y;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_dot  <= n_dot;
        r_sm   <= n_sm;
        r_den  <= n_den;
        r_dev  <= n_dev;
        r_lo2  <= n_lo2;
        r_hi2  <= n_hi2;
        r_x    <= n_x;
        r_last <= n_last;
        r_sx   <= n_sx;
        r_sy   <= n_sy;
        r_sz   <= n_sz;
        r_out  <= n_out;
    end

    atcf_arith #(
        .SW (S),
        .MW (MW),
        .NW (NW),
        .DW (DW)
    ) u_arith (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_req),
        .i_a     (w_a),
        .i_b     (w_b),
        .i_num   (w_num),
        .i_den   (w_dden),
        .i_rad   (w_rad),
        .o_done  (w_done),
        .o_prod  (w_prod),
        .o_quot  (w_quot),
        .o_root  (w_root)
    );

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_tilt_cosine = r_out;
    assign o_cfg_ready   = 1'b1;

    a_y_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_y <= ONE_Y) && (r_y >= -ONE_Y)) else $error("filter state out of range");
    a_idle_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_IDLE) |-> !r_issued) else $error("operation pending in idle");
    a_done_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_done |-> r_issued) else $error("unexpected arith done");

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`default_nettype none

class tilt_scoreboard;
    longint ref_x, ref_y, ref_z;
    bit     ref_ok;
    longint one_g, pct, alpha;
    longint cosine;
    bit     skipping;
    longint ref_len;
    logic signed [15:0] cosine_q[$];
    int     errors;
    int     checked;

    function new();
        ref_x = 0; ref_y = 0; ref_z = 0; ref_ok = 0;
        one_g = 16384; pct = 10; alpha = 6554;
        cosine = 1 << 14; skipping = 0; ref_len = 0;
        errors = 0; checked = 0;
    endfunction

    static function longint int_sqrt(longint v);
        longint r, b;
        r = 0;
        b = longint'(1) << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    static function longint round_div(longint num, longint den);
        longint m, q;
        m = (num < 0) ? -num : num;
        q = (m * 2 + den) / (den * 2);
        return (num < 0) ? -q : q;
    endfunction

    function void write_reg(atcf_pkg::t_cfg_idx idx, logic [16:0] d);
        case (idx)
            atcf_pkg::CFG_REF_X:     ref_x = longint'($signed(d[15:0]));
            atcf_pkg::CFG_REF_Y:     ref_y = longint'($signed(d[15:0]));
            atcf_pkg::CFG_REF_Z:     ref_z = longint'($signed(d[15:0]));
            atcf_pkg::CFG_REF_VALID: ref_ok = d[0];
            atcf_pkg::CFG_ONE_G:     one_g = d[14:0];
            atcf_pkg::CFG_PERCENT:   pct = d[6:0];
            atcf_pkg::CFG_ALPHA:     alpha = d;
            default: ;
        endcase
        ref_len = int_sqrt(ref_x*ref_x + ref_y*ref_y + ref_z*ref_z);
    endfunction

    function void note_sample(logic signed [15:0] ax, logic signed [15:0] ay,
                              logic signed [15:0] az, bit last);
        longint sx, sy, sz, dev, lo, hi, msq, dot, dv, x, a;
        sx = ax; sy = ay; sz = az;
        if (!ref_ok || skipping) begin
            if (last) skipping = 0;
            return;
        end
        dev = (pct * one_g) / 100;
        lo = one_g - dev;
        if (lo < 0) lo = 0;
        hi = one_g + dev;
        msq = sx*sx + sy*sy + sz*sz;
        if (msq < lo*lo || msq > hi*hi) begin
            skipping = !last;
            return;
        end
        dot = ref_x*sx + ref_y*sy + ref_z*sz;
        dv = ref_len * int_sqrt(msq);
        if (dv == 0) begin
            x = 0;
        end else begin
            x = round_div(dot * (1 << 14), dv);
            if (x > (1 << 14)) x = 1 << 14;
            if (x < -(1 << 14)) x = -(1 << 14);
        end
        a = (alpha > 65536) ? 65536 : alpha;
        cosine = cosine + round_div(a * (x - cosine), 65536);
        if (last) begin
            skipping = 0;
            cosine_q.push_back(cosine[15:0]);
        end
    endfunction

    function void check_result(logic signed [15:0] got);
        logic signed [15:0] exp_c;
        if (cosine_q.size() == 0) begin
            $error("unexpected tilt_cosine %0d", got);
            errors++;
            return;
        end
        exp_c = cosine_q.pop_front();
        checked++;
        if (got !== exp_c) begin
            $error("tilt_cosine expected %0d actual %0d", exp_c, got);
            errors++;
        end
    endfunction
endclass

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import atcf_pkg::*;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_valid = 0;
    logic o_ready;
    logic signed [15:0] i_accel_x = 0, i_accel_y = 0, i_accel_z = 0;
    logic i_last_in_batch = 0;
    logic o_valid;
    logic i_ready = 0;
    logic signed [15:0] o_tilt_cosine;
    logic i_cfg_valid = 0;
    logic o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = 0;
    logic [CFG_DATA_W-1:0] i_cfg_data = 0;

    tilt_scoreboard sb;
    longint cycles = 0;
    int items = 0;
    int cfg_writes = 0;
    bit stall_mode = 0;

    localparam longint CYCLE_LIMIT = 3000000;
    localparam int SETTLE = 400;

    always #5 i_clk = ~i_clk;

    accel_tilt_cosine_filter u_top (.*);

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
        if (i_rst_n && o_valid && i_ready) sb.check_result(o_tilt_cosine);
    end

    // receiver stall pattern: phases of always-ready and random stalls
    always @(negedge i_clk) begin
        if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
        i_ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end

    task automatic cfg_write(t_cfg_idx idx, logic [16:0] d);
        i_valid     <= 0;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        i_cfg_valid <= 1;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, d);
        cfg_writes++;
        @(negedge i_clk);
        i_cfg_valid <= 0;
    endtask

    task automatic send(logic signed [15:0] x, logic signed [15:0] y,
                        logic signed [15:0] z, bit last);
        i_accel_x <= x; i_accel_y <= y; i_accel_z <= z;
        i_last_in_batch <= last;
        i_valid <= 1;
        do @(posedge i_clk); while (!o_ready);
        sb.note_sample(x, y, z, last);
        items++;
        @(negedge i_clk);
    endtask

    task automatic pause(int n);
        i_valid <= 0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic drain();
        pause(1);
        while (sb.cosine_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    // sample of roughly magnitude g with random direction
    task automatic near_g(int g, int spread, output logic signed [15:0] x,
                          output logic signed [15:0] y, output logic signed [15:0] z);
        int a, b, c;
        real n;
        a = $urandom_range(0, 2000) - 1000;
        b = $urandom_range(0, 2000) - 1000;
        c = $urandom_range(0, 2000) - 1000;
        if (a == 0 && b == 0 && c == 0) c = 1;
        n = $sqrt(real'(a*a + b*b + c*c));
        g = g + $urandom_range(0, 2*spread) - spread;
        x = $rtoi(a * g / n); y = $rtoi(b * g / n); z = $rtoi(c * g / n);
    endtask

    task automatic random_cfg(bit extreme);
        logic signed [15:0] x, y, z;
        int g;
        g = extreme ? 32767 : $urandom_range(1000, 20000);
        if ($urandom_range(0, 9) == 0) begin
            x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
        end else begin
            near_g(g, 0, x, y, z);
        end
        cfg_write(CFG_REF_X, {1'b0, x});
        cfg_write(CFG_REF_Y, {1'b0, y});
        cfg_write(CFG_REF_Z, {1'b0, z});
        cfg_write(CFG_ONE_G, extreme ? 17'd32767 : 17'(g));
        cfg_write(CFG_PERCENT, extreme ? 17'd127 : 17'($urandom_range(0, 40)));
        case ($urandom_range(0, 3))
            0: cfg_write(CFG_ALPHA, 17'h1FFFF);
            1: cfg_write(CFG_ALPHA, 17'd0);
            default: cfg_write(CFG_ALPHA, 17'($urandom_range(1, 65536)));
        endcase
        cfg_write(CFG_REF_VALID, 17'($urandom_range(0, 7) != 0));
    endtask

    initial begin
        logic signed [15:0] x, y, z;
        int len, burst;
        sb = new();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1;
        @(negedge i_clk);

        // reference invalid: ignored
        send(16384, 0, 0, 1);
        cfg_write(CFG_REF_X, 17'd0);
        cfg_write(CFG_REF_Y, 17'd0);
        cfg_write(CFG_REF_Z, 17'd16384);
        cfg_write(CFG_REF_VALID, 17'd1);
        send(0, 0, 16384, 1);
        send(0, 0, -16384, 1);
        send(0, 16384, 0, 0);
        send(0, 0, 16384, 1);
        send(0, 0, 100, 0);        // fails, skips rest
        send(0, 0, 16384, 1);
        send(0, 0, 30000, 1);      // failing last
        send(16384, 0, 0, 1);
        send(-32768, -32768, -32768, 1);
        send(32767, 32767, 32767, 1);
        drain();
        cfg_write(CFG_PERCENT, 17'd127);
        cfg_write(CFG_ALPHA, 17'h1FFFF);
        send(0, 0, 0, 1);           // zero divisor
        send(0, 0, 16384, 1);
        send(-32768, 0, 0, 1);
        drain();
        cfg_write(CFG_ALPHA, 17'd0);
        send(0, 0, -16384, 1);
        drain();
        cfg_write(CFG_ONE_G, 17'd1);
        cfg_write(CFG_PERCENT, 17'd0);
        cfg_write(CFG_ALPHA, 17'd65536);
        send(0, 0, 1, 1);
        send(0, -1, 0, 1);
        drain();

        for (int phase = 0; phase < 12; phase++) begin
            random_cfg(phase == 3);
            for (int k = 0; k < 37; k++) begin
                len = $urandom_range(1, 5);
                for (int s = 0; s < len; s++) begin
                    if ($urandom_range(0, 9) == 0) begin
                        x = 16'($urandom); y = 16'($urandom); z = 16'($urandom);
                    end else begin
                        near_g(sb.one_g, sb.one_g * (sb.pct + 3) / 100, x, y, z);
                    end
                    send(x, y, z, s == len - 1);
                    burst = $urandom_range(0, 3);
                    if (burst == 0) pause($urandom_range(1, 30));
                end
                if (k == 20 && phase == 5) drain();
            end
            drain();
        end

        $display("Sent %0d samples in %0d config writes; checked %0d filter outputs.",
                 items, cfg_writes, sb.checked);
        if (sb.errors == 0 && sb.cosine_q.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule

`default_nettype wire

// ===== accel_tilt_cosine_filter.f =====
rtl/core/atcf_pkg.sv
rtl/core/atcf_arith.sv
rtl/core/accel_tilt_cosine_filter.sv
sim/tb_top.sv
